/* hdl/accel_tilt_pitch_angle_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for accel_tilt_pitch_angle
// Checks sampled at clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_PITCH_ANGLE_DEFINES_SVH
`define ACCEL_TILT_PITCH_ANGLE_DEFINES_SVH

// same-cycle implication
`define ATP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ATP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/atp_pkg.sv */
// ---------------------------------------------------------------------------
// atp_pkg
// Shared types and constants for the accelerometer pitch angle block.
// ---------------------------------------------------------------------------
package atp_pkg;

  localparam int CW = 3;    // channel tag
  localparam int DW = 16;   // raw samples, offsets, pitch
  localparam int AW = 21;   // corrected axis, counts*16
  localparam int PW = 34;   // CORDIC x/y datapath
  localparam int ZW = 26;   // angle accumulator, degrees Q16
  localparam int GUARD = 10;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int KW = 30;
  localparam logic [KW-1:0] INV_GAIN = 30'd652032874;  // round(2^30/K)
  localparam int PITCH_LIMIT = 23040;

  localparam logic [21:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } reg_idx_t;

  // item tag carried alongside the datapath
  typedef struct packed {
    logic          valid;
    logic [CW-1:0] channel;
    logic          nz;       // negated x is nonzero
  } tag_t;

endpackage

/* hdl/accel_tilt_pitch_angle.sv */
// ---------------------------------------------------------------------------
// accel_tilt_pitch_angle
// Pitch = atan2(-x, sqrt(y^2 + z^2)) in Q8.8 degrees from one offset-corrected
// accelerometer sample, by two rows of pipelined CORDIC cells.
// ---------------------------------------------------------------------------
// A new item may be started in every cycle; busy is always low. Each item's
// result appears on out_valid after one correction stage, N magnitude cells,
// two gain multiply stages, N angle cells and one rounding stage, where N is
// CORDIC_STAGES (capped at 24). Results cannot be held off and are shown for
// one cycle only. Offsets may be written at any time no item is in flight.
module accel_tilt_pitch_angle #(
  parameter int CORDIC_STAGES = atp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [atp_pkg::CW-1:0]       in_sensor_channel,
  input  logic signed [atp_pkg::DW-1:0] in_raw_x,
  input  logic signed [atp_pkg::DW-1:0] in_raw_y,
  input  logic signed [atp_pkg::DW-1:0] in_raw_z,
  output logic                         out_valid,
  output logic [atp_pkg::CW-1:0]       out_channel_out,
  output logic signed [atp_pkg::DW-1:0] out_pitch_deg,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [atp_pkg::DW-1:0]       cfg_wdata
);
  import atp_pkg::*;

  localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // configuration
  logic signed [DW-1:0] off_x_r, off_y_r, off_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= 16'sd3277;
      off_y_r <= -16'sd655;
      off_z_r <= 16'sd1966;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_X: off_x_r <= cfg_wdata;
        REG_OFFSET_Y: off_y_r <= cfg_wdata;
        REG_OFFSET_Z: off_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // correction stage
  logic signed [AW-1:0] cx, cy, cz, cy_abs;
  logic signed [AW-1:0] py_r, pz_r, pnum_r;
  tag_t                 ptag_r;

  always_comb begin
    cx     = AW'($signed({in_raw_x, 4'b0000})) - AW'(off_x_r);
    cy     = AW'($signed({in_raw_y, 4'b0000})) - AW'(off_y_r);
    cz     = AW'($signed({in_raw_z, 4'b0000})) - AW'(off_z_r);
    cy_abs = cy[AW-1] ? -cy : cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptag_r.valid <= 1'b0;
    end else begin
      ptag_r.valid <= start && !busy;
    end
    py_r           <= cy_abs;
    pz_r           <= cz;
    pnum_r         <= -cx;
    ptag_r.channel <= in_sensor_channel;
    ptag_r.nz      <= |cx;
  end

  // magnitude row
  logic signed [PW-1:0] mx [N+1];
  logic signed [PW-1:0] my [N+1];
  logic signed [AW-1:0] mn [N+1];
  tag_t                 mt [N+1];

  assign mx[0] = PW'(py_r) <<< GUARD;
  assign my[0] = PW'(pz_r) <<< GUARD;
  assign mn[0] = pnum_r;
  assign mt[0] = ptag_r;

  for (genvar i = 0; i < N; i++) begin : g_mag
    atp_cell #(.STAGE(i), .W(PW), .ZBITS(AW), .ACC(1'b0)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_x   (mx[i]),
      .in_y   (my[i]),
      .in_z   (mn[i]),
      .in_tag (mt[i]),
      .out_x  (mx[i+1]),
      .out_y  (my[i+1]),
      .out_z  (mn[i+1]),
      .out_tag(mt[i+1])
    );
  end

  // gain compensation
  logic signed [PW-1:0] mag;
  logic signed [AW-1:0] gnum;
  tag_t                 gtag;

  atp_gain u_gain (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_x   (mx[N]),
    .in_num (mn[N]),
    .in_tag (mt[N]),
    .out_mag(mag),
    .out_num(gnum),
    .out_tag(gtag)
  );

  // angle row
  logic signed [PW-1:0] ax [N+1];
  logic signed [PW-1:0] ay [N+1];
  logic signed [ZW-1:0] az [N+1];
  tag_t                 at [N+1];

  assign ax[0] = mag;
  assign ay[0] = PW'(gnum) <<< GUARD;
  assign az[0] = '0;
  assign at[0] = gtag;

  for (genvar i = 0; i < N; i++) begin : g_ang
    atp_cell #(.STAGE(i), .W(PW), .ZBITS(ZW), .ACC(1'b1)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_x   (ax[i]),
      .in_y   (ay[i]),
      .in_z   (az[i]),
      .in_tag (at[i]),
      .out_x  (ax[i+1]),
      .out_y  (ay[i+1]),
      .out_z  (az[i+1]),
      .out_tag(at[i+1])
    );
  end

  // round, clamp, zero case
  localparam logic signed [ZW-1:0] LIM = ZW'(PITCH_LIMIT);

  logic signed [ZW-1:0] rnd;
  logic signed [DW-1:0] pitch_nxt, pitch_r;
  logic [CW-1:0]        chan_r;
  logic                 valid_r;

  always_comb begin
    rnd = (az[N] + ZW'(128)) >>> 8;
    if (!at[N].nz) begin
      pitch_nxt = '0;
    end else if (rnd > LIM) begin
      pitch_nxt = DW'(LIM);
    end else if (rnd < -LIM) begin
      pitch_nxt = DW'(-LIM);
    end else begin
      pitch_nxt = DW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= at[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r <= pitch_nxt;
    chan_r  <= at[N].channel;
  end

  assign out_valid       = valid_r;
  assign out_channel_out = chan_r;
  assign out_pitch_deg   = pitch_r;

  `include "accel_tilt_pitch_angle_defines.svh"

  `ATP_ASSERT_NOW(a_pitch_range, out_valid,
                  out_pitch_deg <= 16'sd23040 && out_pitch_deg >= -16'sd23040,
                  "pitch out of range")
  `ATP_ASSERT_NEXT(a_zero_x, at[N].valid && !at[N].nz, out_valid && out_pitch_deg == 0,
                   "zero x did not give zero pitch")
  `ATP_ASSERT_NEXT(a_out_follow, at[N].valid, out_valid, "result lost at output")

endmodule

/* hdl/atp_cell.sv */
// ---------------------------------------------------------------------------
// atp_cell
// One vectoring CORDIC micro-rotation, registered. With ACC set the cell adds its
// table angle to z when y is positive and subtracts it otherwise; otherwise z passes through as a side value.
// ---------------------------------------------------------------------------
module atp_cell #(
  parameter int STAGE = 0,
  parameter int W     = 34,
  parameter int ZBITS = 26,
  parameter bit ACC   = 1'b1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [W-1:0]     in_x,
  input  logic signed [W-1:0]     in_y,
  input  logic signed [ZBITS-1:0] in_z,
  input  atp_pkg::tag_t           in_tag,
  output logic signed [W-1:0]     out_x,
  output logic signed [W-1:0]     out_y,
  output logic signed [ZBITS-1:0] out_z,
  output atp_pkg::tag_t           out_tag
);
  import atp_pkg::*;

  localparam logic signed [ZBITS-1:0] ANG = ZBITS'(ATAN_DEG_Q16[STAGE]);

  logic signed [W-1:0]     dx, dy;
  logic signed [W-1:0]     x_nxt, y_nxt, x_r, y_r;
  logic signed [ZBITS-1:0] z_nxt, z_r;
  tag_t                    tag_r;

  always_comb begin
    dx = in_y >>> STAGE;
    dy = in_x >>> STAGE;
    if (in_y > 0) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = ACC ? in_z + ANG : in_z;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = ACC ? in_z - ANG : in_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= in_tag.valid;
    end
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    z_r           <= z_nxt;
    tag_r.channel <= in_tag.channel;
    tag_r.nz      <= in_tag.nz;
  end

  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_tag = tag_r;

endmodule

/* hdl/atp_gain.sv */
// ---------------------------------------------------------------------------
// atp_gain
// CORDIC gain compensation: floor(x * round(2^30/K) / 2^30), split into two
// partial products and summed in the following stage.
// ---------------------------------------------------------------------------
module atp_gain (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [atp_pkg::PW-1:0] in_x,
  input  logic signed [atp_pkg::AW-1:0] in_num,
  input  atp_pkg::tag_t                 in_tag,
  output logic signed [atp_pkg::PW-1:0] out_mag,
  output logic signed [atp_pkg::AW-1:0] out_num,
  output atp_pkg::tag_t                 out_tag
);
  import atp_pkg::*;

  localparam int LB = 17;
  localparam int HB = PW - LB;
  localparam int SW = 64;

  logic        [LB+KW-1:0]   plo_r;
  logic signed [HB+KW:0]     phi_r;
  logic signed [AW-1:0]      num1_r, num2_r;
  tag_t                      tag1_r, tag2_r;
  logic signed [PW-1:0]      mag_r;
  logic signed [SW-1:0]      sum;
  logic signed [HB-1:0]      xh;
  logic        [LB-1:0]      xl;

  assign xl = in_x[LB-1:0];
  assign xh = in_x[PW-1:LB];

  always_comb begin
    sum = (SW'(phi_r) <<< LB) + SW'($signed({1'b0, plo_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
    end else begin
      tag1_r.valid <= in_tag.valid;
      tag2_r.valid <= tag1_r.valid;
    end
    plo_r          <= (LB+KW)'(xl) * (LB+KW)'(INV_GAIN);
    phi_r          <= (HB+KW+1)'(xh) * (HB+KW+1)'($signed({1'b0, INV_GAIN}));
    num1_r         <= in_num;
    tag1_r.channel <= in_tag.channel;
    tag1_r.nz      <= in_tag.nz;
    mag_r          <= PW'(sum >>> KW);
    num2_r         <= num1_r;
    tag2_r.channel <= tag1_r.channel;
    tag2_r.nz      <= tag1_r.nz;
  end

  assign out_mag = mag_r;
  assign out_num = num2_r;
  assign out_tag = tag2_r;

  `include "accel_tilt_pitch_angle_defines.svh"

  `ATP_ASSERT_NEXT(a_gain_flow, tag1_r.valid, tag2_r.valid, "gain stage dropped an item")
  `ATP_ASSERT_NEXT(a_gain_in, in_tag.valid, tag1_r.valid, "gain stage lost an item")
  `ATP_ASSERT_NEXT(a_gain_idle, !in_tag.valid && !tag1_r.valid, !tag2_r.valid,
                   "gain stage invented an item")

endmodule

/* bench/accel_tilt_pitch_angle_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_angle testbench
// Drives accelerometer samples into the pitch block under several offset
// settings and sender gap rates, predicts each pitch with a bit-exact
// two-pass CORDIC model and checks every result item in order.
// ----------------------------------------------------------------------------
module testbench;
  import atp_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int STAGE_CAP = 24;
  localparam int STAGES = (CORDIC_STAGES > STAGE_CAP) ? STAGE_CAP : CORDIC_STAGES;
  localparam int LATENCY = 2 * STAGES + 4;
  localparam longint GUARD_SCALE = 1024;
  localparam longint GAIN_COMP = 652032874;
  localparam longint PITCH_MAX = 23040;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam longint ATAN_Q16 [STAGE_CAP] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum int {
    OFFS_RANDOM,
    OFFS_ALIGNED,
    OFFS_ZERO,
    OFFS_MAX,
    OFFS_MIN
  } offset_mode_t;

  typedef enum int {
    KIND_FULL,
    KIND_GRAVITY,
    KIND_X_CANCEL,
    KIND_YZ_CANCEL,
    KIND_EXTREME,
    KIND_SMALL
  } sample_kind_t;

  typedef struct {
    logic [CW-1:0]        channel;
    logic signed [DW-1:0] pitch;
  } pitch_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CW-1:0]        in_sensor_channel = '0;
  logic signed [DW-1:0] in_raw_x = '0;
  logic signed [DW-1:0] in_raw_y = '0;
  logic signed [DW-1:0] in_raw_z = '0;
  logic                 out_valid;
  logic [CW-1:0]        out_channel_out;
  logic signed [DW-1:0] out_pitch_deg;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [DW-1:0]        cfg_wdata = '0;

  logic signed [DW-1:0] off_x = 16'sd3277;
  logic signed [DW-1:0] off_y = -16'sd655;
  logic signed [DW-1:0] off_z = 16'sd1966;

  pitch_result_t expected_pitch [$];
  int            fail_count = 0;
  int            cycle_count = 0;

  accel_tilt_pitch_angle #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_sensor_channel(in_sensor_channel),
    .in_raw_x(in_raw_x),
    .in_raw_y(in_raw_y),
    .in_raw_z(in_raw_z),
    .out_valid(out_valid),
    .out_channel_out(out_channel_out),
    .out_pitch_deg(out_pitch_deg),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("accel_tilt_pitch_angle verification failed");
      $finish;
    end
  end

  // vectoring CORDIC, floor shifts, angle in degrees Q16
  function automatic void cordic_vector(inout longint px, inout longint py,
                                        output longint ang);
    longint dx, dy;
    ang = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (py > 0) begin
        px += dx;
        py -= dy;
        ang += ATAN_Q16[i];
      end else begin
        px -= dx;
        py += dy;
        ang -= ATAN_Q16[i];
      end
    end
  endfunction

  function automatic logic signed [DW-1:0] predict_pitch(input logic signed [DW-1:0] rx,
                                                          input logic signed [DW-1:0] ry,
                                                          input logic signed [DW-1:0] rz);
    longint cx, cy, cz, px, py, ang, mag, p;
    cx = longint'(rx) * 16 - longint'(off_x);
    cy = longint'(ry) * 16 - longint'(off_y);
    cz = longint'(rz) * 16 - longint'(off_z);
    if (cx == 0) return '0;
    px = (cy < 0 ? -cy : cy) * GUARD_SCALE;
    py = cz * GUARD_SCALE;
    cordic_vector(px, py, ang);
    mag = (px * GAIN_COMP) >>> 30;
    px = mag;
    py = -cx * GUARD_SCALE;
    cordic_vector(px, py, ang);
    p = (ang + 128) >>> 8;
    if (p > PITCH_MAX) p = PITCH_MAX;
    if (p < -PITCH_MAX) p = -PITCH_MAX;
    return p[DW-1:0];
  endfunction

  // result check first, then record the item accepted at this edge
  always @(posedge clk) begin : check_results
    pitch_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_pitch.size() == 0) begin
          $error("result item with no expectation: channel_out %0d pitch_deg %0d",
                 out_channel_out, out_pitch_deg);
          fail_count++;
        end else begin
          want = expected_pitch.pop_front();
          if (out_channel_out !== want.channel) begin
            $error("channel_out: expected %0d, actual %0d", want.channel, out_channel_out);
            fail_count++;
          end
          if (out_pitch_deg !== want.pitch) begin
            $error("pitch_deg: expected %0d, actual %0d", want.pitch, out_pitch_deg);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        want.channel = in_sensor_channel;
        want.pitch = predict_pitch(in_raw_x, in_raw_y, in_raw_z);
        expected_pitch.push_back(want);
      end
    end
  end

  task automatic send_sample(input logic [CW-1:0] ch, input logic signed [DW-1:0] x,
                             input logic signed [DW-1:0] y, input logic signed [DW-1:0] z,
                             input int gap_pct);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_sensor_channel <= ch;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    while (expected_pitch.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_offset(input logic [1:0] idx, input logic [DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_X: off_x = val;
      REG_OFFSET_Y: off_y = val;
      REG_OFFSET_Z: off_z = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_offsets(input logic [DW-1:0] ox, input logic [DW-1:0] oy,
                             input logic [DW-1:0] oz);
    write_offset(REG_OFFSET_X, ox);
    write_offset(REG_OFFSET_Y, oy);
    write_offset(REG_OFFSET_Z, oz);
  endtask

  function automatic logic signed [DW-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  task automatic test_reset_values();
    send_sample(3'd0, 16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_sample(3'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_sample(3'd5, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_sample(3'd2, 16'sh1000, 16'sh0000, 16'sh0000, 0);
    send_sample(3'd3, 16'shf000, 16'sh0000, 16'sh1000, 0);
    wait_until_idle();
  endtask

  task automatic test_zero_vectors();
    set_offsets(16'h0000, 16'h0000, 16'h0000);
    send_sample(3'd1, 16'sh0000, 16'sh0000, 16'sh0000, 0);   // atan2(0,0)
    send_sample(3'd6, 16'sh0000, 16'sh03e8, 16'shfc18, 0);   // zero x
    send_sample(3'd4, 16'sh0001, 16'sh0000, 16'sh0000, 0);   // no y/z magnitude
    send_sample(3'd0, 16'shffff, 16'sh0000, 16'sh0000, 0);
    send_sample(3'd7, 16'sh7fff, 16'sh0000, 16'sh0000, 0);
    send_sample(3'd2, 16'sh8000, 16'sh0000, 16'sh0000, 0);
    wait_until_idle();
  endtask

  task automatic test_offset_extremes();
    set_offsets(16'h7fff, 16'h8000, 16'h7fff);
    send_sample(3'd3, 16'sh8000, 16'sh7fff, 16'sh8000, 0);
    send_sample(3'd5, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send_sample(3'd1, 16'sh0000, 16'sh0000, 16'sh0000, 0);
    wait_until_idle();
    set_offsets(16'h8000, 16'h7fff, 16'h8000);
    send_sample(3'd6, 16'sh8000, 16'sh7fff, 16'sh8000, 0);
    send_sample(3'd4, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send_sample(3'd7, 16'shf800, 16'sh0000, 16'sh0000, 0);   // -x cancels offset
    wait_until_idle();
  endtask

  task automatic test_unused_index();
    write_offset(REG_UNUSED, 16'hffff);
    send_sample(3'd0, 16'sh0000, 16'sh0000, 16'sh0000, 0);
    send_sample(3'd5, 16'sh0123, 16'shfedc, 16'sh0800, 0);
    wait_until_idle();
  endtask

  task automatic test_random_samples(input offset_mode_t mode, input int count,
                                     input int gap_pct);
    logic signed [DW-1:0] rx, ry, rz;
    logic [CW-1:0]        ch;
    sample_kind_t         kind;
    case (mode)
      OFFS_RANDOM:  set_offsets(DW'($urandom), DW'($urandom), DW'($urandom));
      OFFS_ALIGNED: set_offsets(DW'($urandom & 16'hfff0), DW'($urandom & 16'hfff0),
                                DW'($urandom & 16'hfff0));
      OFFS_ZERO:    set_offsets(16'h0000, 16'h0000, 16'h0000);
      OFFS_MAX:     set_offsets(16'h7fff, 16'h7fff, 16'h7fff);
      default:      set_offsets(16'h8000, 16'h8000, 16'h8000);
    endcase
    for (int k = 0; k < count; k++) begin
      ch = CW'($urandom);
      rx = DW'($urandom);
      ry = DW'($urandom);
      rz = DW'($urandom);
      kind = sample_kind_t'($urandom_range(KIND_SMALL));
      case (kind)
        KIND_GRAVITY: begin
          rx = DW'($urandom_range(8192) - 4096);
          ry = DW'($urandom_range(8192) - 4096);
          rz = DW'($urandom_range(8192) - 4096);
        end
        KIND_X_CANCEL: rx = off_x >>> 4;
        KIND_YZ_CANCEL: begin
          ry = off_y >>> 4;
          rz = off_z >>> 4;
        end
        KIND_EXTREME: begin
          rx = pick_extreme();
          ry = pick_extreme();
          rz = pick_extreme();
        end
        KIND_SMALL: begin
          rx = DW'($urandom_range(64) - 32);
          ry = DW'($urandom_range(64) - 32);
          rz = DW'($urandom_range(64) - 32);
        end
        default: ;
      endcase
      send_sample(ch, rx, ry, rz, gap_pct);
    end
    wait_until_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_zero_vectors();
    test_offset_extremes();
    test_unused_index();
    test_random_samples(OFFS_RANDOM, 160, 0);
    test_random_samples(OFFS_ALIGNED, 160, 45);
    test_random_samples(OFFS_ZERO, 160, 37);
    test_random_samples(OFFS_MAX, 160, 45);
    test_random_samples(OFFS_MIN, 160, 0);
    if (fail_count == 0) begin
      $display("accel_tilt_pitch_angle verification clean");
    end else begin
      $display("accel_tilt_pitch_angle verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/atp_pkg.sv
hdl/atp_cell.sv
hdl/atp_gain.sv
hdl/accel_tilt_pitch_angle.sv
bench/accel_tilt_pitch_angle_tb.sv
